// ----- design/pses_pkg.sv -----
// Package for the per-pixel sorted event store.
// Holds request and result structs and the mode and status codes.
// No dependencies.
package pses_pkg;

  localparam logic [1:0] MODE_INSERT  = 2'd0;
  localparam logic [1:0] MODE_FIND    = 2'd1;
  localparam logic [1:0] MODE_RANGE   = 2'd2;
  localparam logic [1:0] MODE_DESTROY = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [47:0] event_time;
    logic [15:0] tot_value;
    logic [47:0] min_time;
    logic [47:0] max_time;
  } pses_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] out_time;
    logic [15:0] out_tot;
    logic        live;
    logic [4:0]  range_start;
    logic [4:0]  range_count;
    logic        last_of_run;
  } pses_out_t;

endpackage

// ----- design/pses_evmem.sv -----
// Event memory of the sorted event store: timestamp and tot arrays.
// One registered read port, one write port with separate field enables.
// No package dependencies.
module pses_evmem #(
  parameter int AW = 20,
  parameter int TW = 48
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [TW-1:0] rd_time,
  output logic [15:0]   rd_tot,
  input  logic          wr_time_en,
  input  logic          wr_tot_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [TW-1:0] wr_time,
  input  logic [15:0]   wr_tot
);

  logic [TW-1:0] time_mem [0:(1<<AW)-1];
  logic [15:0]   tot_mem  [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (wr_time_en) begin
      time_mem[wr_addr] <= wr_time;
    end
    if (wr_tot_en) begin
      tot_mem[wr_addr] <= wr_tot;
    end
    rd_time <= time_mem[rd_addr];
    rd_tot  <= tot_mem[rd_addr];
  end

endmodule

// ----- design/pses_metamem.sv -----
// Per-bucket bookkeeping memory: fill count, start index, remaining count.
// One registered read port and one write port; no package dependencies.
module pses_metamem #(
  parameter int AW = 16,
  parameter int DW = 15
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] meta_mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      meta_mem[wr_addr] <= wr_data;
    end
    rd_data <= meta_mem[rd_addr];
  end

endmodule

// ----- design/per_pixel_sorted_event_store.sv -----
// Top level of the per-pixel sorted event store: request sequencer.
// Uses pses_pkg, pses_evmem and pses_metamem.
//
// A request is taken on a clock edge with start high and busy low. It selects
// a bucket by pixel and runs one of four modes: insert, find first live,
// range query or destroy range. Results appear on out_data for one cycle each,
// marked by out_valid; the receiver cannot stall them, and last_of_run marks
// the final result of a request. busy stays high until that result is out.
// One request walks its bucket entry by entry through a single registered
// memory read port: a read state and a check or emit state per entry for the
// insert shift, the find scan, the range search and the range listing, and one
// write state per entry for the destroy pass. A request passes through the
// pixel reduction (repeated while a coordinate is beyond MATRIX_SIDE), a
// bookkeeping read, then the insert shift, the find scan or the range search,
// and for a range query or destroy the range listing or destroy pass.
// After reset a clearing pass writes zero bookkeeping to every bucket, one
// per cycle, MATRIX_SIDE*MATRIX_SIDE buckets (65536 by default), with busy high.
module per_pixel_sorted_event_store #(
  parameter int MATRIX_SIDE  = 256,
  parameter int BUCKET_DEPTH = 16,
  parameter int TIME_WIDTH   = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pses_pkg::pses_in_t in_data,
  output logic               out_valid,
  output pses_pkg::pses_out_t out_data
);
  import pses_pkg::*;

  localparam int NB  = MATRIX_SIDE * MATRIX_SIDE;
  localparam int BW  = $clog2(NB);
  localparam int DW  = $clog2(BUCKET_DEPTH);
  localparam int CW  = $clog2(BUCKET_DEPTH + 1);
  localparam int TW  = TIME_WIDTH;
  localparam int AW  = BW + DW;
  localparam int MW  = 3 * CW;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_REDUCE, ST_MREAD, ST_MWAIT,
    ST_INS_RD, ST_INS_CHK, ST_INS_PUT, ST_FND_RD, ST_FND_CHK,
    ST_SRC_RD, ST_SRC_CHK, ST_SRC_END, ST_LST_RD, ST_LST_EMIT, ST_DES_WR
  } state_t;

  state_t        state_r;
  logic [BW-1:0] clr_r;
  logic [1:0]    mode_r;
  logic [7:0]    x_r, y_r;
  logic [BW-1:0] b_r;
  logic [TW-1:0] key_r, min_r, max_r;
  logic [15:0]   tot_r;
  logic [CW-1:0] n_r, s_r, rem_r, fill_raw_r, start_raw_r;
  logic [CW-1:0] i_r, lo_r, hi_r;
  logic          lo_f_r, hi_f_r;
  logic          out_valid_r;
  pses_out_t     out_r;

  logic [BW-1:0] bucket;
  logic [CW-1:0] size;
  logic [CW-1:0] fill_m, start_m, rem_m, n_m;
  logic [MW-1:0] meta_rd;
  logic          meta_we;
  logic [BW-1:0] meta_waddr;
  logic [MW-1:0] meta_wdata;
  logic [DW-1:0] ev_ridx, ev_widx;
  logic [TW-1:0] ev_rtime, ev_wtime;
  logic [15:0]   ev_rtot, ev_wtot;
  logic          ev_wt_en, ev_wo_en;
  logic          accept;
  logic          last_item;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign bucket    = BW'(32'(x_r) + 32'(y_r) * MATRIX_SIDE);
  assign size      = (hi_r > lo_r) ? CW'(hi_r - lo_r) : '0;
  assign fill_m    = meta_rd[3*CW-1:2*CW];
  assign start_m   = meta_rd[2*CW-1:CW];
  assign rem_m     = meta_rd[CW-1:0];
  assign n_m       = (fill_m > CW'(BUCKET_DEPTH)) ? CW'(BUCKET_DEPTH) : fill_m;
  assign last_item = (CW'(i_r + 1'b1) == hi_r);

  pses_metamem #(.AW(BW), .DW(MW)) u_meta (
    .clk     (clk),
    .rd_addr (bucket),
    .rd_data (meta_rd),
    .wr_en   (meta_we),
    .wr_addr (meta_waddr),
    .wr_data (meta_wdata)
  );

  pses_evmem #(.AW(AW), .TW(TW)) u_ev (
    .clk        (clk),
    .rd_addr    ({b_r, ev_ridx}),
    .rd_time    (ev_rtime),
    .rd_tot     (ev_rtot),
    .wr_time_en (ev_wt_en),
    .wr_tot_en  (ev_wo_en),
    .wr_addr    ({b_r, ev_widx}),
    .wr_time    (ev_wtime),
    .wr_tot     (ev_wtot)
  );

  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = b_r;
    meta_wdata = {fill_raw_r, start_raw_r, rem_r};
    ev_ridx    = i_r[DW-1:0];
    ev_widx    = i_r[DW-1:0];
    ev_wtime   = ev_rtime;
    ev_wtot    = ev_rtot;
    ev_wt_en   = 1'b0;
    ev_wo_en   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_r;
        meta_wdata = '0;
      end
      ST_INS_RD: begin
        ev_ridx = DW'(i_r - 1'b1);
      end
      ST_INS_CHK: begin
        ev_wt_en = (ev_rtime > key_r);
        ev_wo_en = (ev_rtime > key_r);
      end
      ST_INS_PUT: begin
        ev_wtime   = key_r;
        ev_wtot    = tot_r;
        ev_wt_en   = 1'b1;
        ev_wo_en   = 1'b1;
        meta_we    = 1'b1;
        meta_wdata = {CW'(n_r + 1'b1), start_raw_r,
                      (rem_r < CW'(BUCKET_DEPTH)) ? CW'(rem_r + 1'b1) : rem_r};
      end
      ST_FND_RD: begin
        meta_we    = (i_r >= n_r);
        meta_wdata = {fill_raw_r, i_r, rem_r};
      end
      ST_FND_CHK: begin
        meta_we    = (ev_rtot != '0);
        meta_wdata = {fill_raw_r, i_r, rem_r};
      end
      ST_DES_WR: begin
        ev_wtot    = '0;
        ev_wo_en   = (i_r < hi_r);
        meta_we    = (i_r >= hi_r);
        meta_wdata = {fill_raw_r, (s_r == lo_r) ? hi_r : start_raw_r,
                      (rem_r > size) ? CW'(rem_r - size) : CW'(0)};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= BW'(clr_r + 1'b1);
          if (clr_r == BW'(NB - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            mode_r  <= in_data.mode;
            x_r     <= in_data.pixel_x;
            y_r     <= in_data.pixel_y;
            key_r   <= TW'(in_data.event_time);
            tot_r   <= in_data.tot_value;
            min_r   <= TW'(in_data.min_time);
            max_r   <= TW'(in_data.max_time);
            state_r <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          if (32'(x_r) >= MATRIX_SIDE) begin
            x_r <= 8'(32'(x_r) - MATRIX_SIDE);
          end
          if (32'(y_r) >= MATRIX_SIDE) begin
            y_r <= 8'(32'(y_r) - MATRIX_SIDE);
          end
          if (32'(x_r) < MATRIX_SIDE && 32'(y_r) < MATRIX_SIDE) begin
            state_r <= ST_MREAD;
          end
        end
        ST_MREAD: begin
          b_r     <= bucket;
          state_r <= ST_MWAIT;
        end
        ST_MWAIT: begin
          fill_raw_r  <= fill_m;
          start_raw_r <= start_m;
          rem_r       <= rem_m;
          n_r         <= n_m;
          s_r         <= (start_m > n_m) ? n_m : start_m;
          lo_f_r      <= 1'b0;
          hi_f_r      <= 1'b0;
          i_r         <= (start_m > n_m) ? n_m : start_m;
          unique case (mode_r)
            MODE_INSERT: begin
              i_r <= n_m;
              if (n_m >= CW'(BUCKET_DEPTH)) begin
                out_valid_r <= 1'b1;
                out_r <= '{status: STAT_FULL, out_time: 48'(key_r), out_tot: tot_r,
                           live: (tot_r != '0), range_start: 5'(BUCKET_DEPTH),
                           range_count: '0, last_of_run: 1'b1};
                state_r <= ST_IDLE;
              end else begin
                state_r <= ST_INS_RD;
              end
            end
            MODE_FIND: begin
              if (rem_m == '0) begin
                out_valid_r <= 1'b1;
                out_r <= '{status: STAT_EMPTY, out_time: '0, out_tot: '0, live: 1'b0,
                           range_start: 5'((start_m > n_m) ? n_m : start_m),
                           range_count: '0, last_of_run: 1'b1};
                state_r <= ST_IDLE;
              end else begin
                state_r <= ST_FND_RD;
              end
            end
            default: begin
              state_r <= ST_SRC_RD;
            end
          endcase
        end
        ST_INS_RD: begin
          state_r <= (i_r == '0) ? ST_INS_PUT : ST_INS_CHK;
        end
        ST_INS_CHK: begin
          if (ev_rtime > key_r) begin
            i_r     <= CW'(i_r - 1'b1);
            state_r <= ST_INS_RD;
          end else begin
            state_r <= ST_INS_PUT;
          end
        end
        ST_INS_PUT: begin
          out_valid_r <= 1'b1;
          out_r <= '{status: STAT_OK, out_time: 48'(key_r), out_tot: tot_r,
                     live: (tot_r != '0), range_start: 5'(i_r),
                     range_count: '0, last_of_run: 1'b1};
          state_r <= ST_IDLE;
        end
        ST_FND_RD: begin
          if (i_r >= n_r) begin
            out_valid_r <= 1'b1;
            out_r <= '{status: STAT_EMPTY, out_time: '0, out_tot: '0, live: 1'b0,
                       range_start: 5'(i_r), range_count: '0, last_of_run: 1'b1};
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_FND_CHK;
          end
        end
        ST_FND_CHK: begin
          if (ev_rtot == '0) begin
            i_r     <= CW'(i_r + 1'b1);
            state_r <= ST_FND_RD;
          end else begin
            out_valid_r <= 1'b1;
            out_r <= '{status: STAT_OK, out_time: 48'(ev_rtime), out_tot: ev_rtot,
                       live: 1'b1, range_start: 5'(i_r), range_count: '0,
                       last_of_run: 1'b1};
            state_r <= ST_IDLE;
          end
        end
        ST_SRC_RD: begin
          if (i_r >= n_r || (lo_f_r && hi_f_r)) begin
            if (!lo_f_r) begin
              lo_r <= n_r;
            end
            if (!hi_f_r) begin
              hi_r <= n_r;
            end
            state_r <= ST_SRC_END;
          end else begin
            state_r <= ST_SRC_CHK;
          end
        end
        ST_SRC_CHK: begin
          if (!lo_f_r && ev_rtime >= min_r) begin
            lo_r   <= i_r;
            lo_f_r <= 1'b1;
          end
          if (!hi_f_r && ev_rtime > max_r) begin
            hi_r   <= i_r;
            hi_f_r <= 1'b1;
          end
          i_r     <= CW'(i_r + 1'b1);
          state_r <= ST_SRC_RD;
        end
        ST_SRC_END: begin
          i_r <= lo_r;
          if (mode_r == MODE_DESTROY) begin
            state_r <= ST_DES_WR;
          end else if (size == '0) begin
            out_valid_r <= 1'b1;
            out_r <= '{status: STAT_EMPTY, out_time: '0, out_tot: '0, live: 1'b0,
                       range_start: 5'(lo_r), range_count: '0, last_of_run: 1'b1};
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_LST_RD;
          end
        end
        ST_LST_RD: begin
          state_r <= ST_LST_EMIT;
        end
        ST_LST_EMIT: begin
          out_valid_r <= 1'b1;
          out_r <= '{status: STAT_OK, out_time: 48'(ev_rtime), out_tot: ev_rtot,
                     live: (ev_rtot != '0), range_start: 5'(lo_r),
                     range_count: 5'(size), last_of_run: last_item};
          i_r     <= CW'(i_r + 1'b1);
          state_r <= last_item ? ST_IDLE : ST_LST_RD;
        end
        ST_DES_WR: begin
          if (i_r >= hi_r) begin
            out_valid_r <= 1'b1;
            out_r <= '{status: (size != '0) ? STAT_OK : STAT_EMPTY, out_time: '0,
                       out_tot: '0, live: 1'b0, range_start: 5'(lo_r),
                       range_count: 5'(size), last_of_run: 1'b1};
            state_r <= ST_IDLE;
          end else begin
            i_r <= CW'(i_r + 1'b1);
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_accept_reduce: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_REDUCE))
    else $error("accepted request did not start the sequencer");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_of_run) |-> !busy)
    else $error("final result issued while still busy");

  a_ins_chk_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS_CHK) |-> (i_r != '0))
    else $error("insert shift compared below bucket start");

  a_full_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == STAT_FULL) |-> (out_data.range_start == 5'(BUCKET_DEPTH)))
    else $error("full-bucket result has wrong position");

  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last_of_run) |-> busy)
    else $error("run ended without a final result");

endmodule
